// ----- rtl/core/midi_song_step_sequencer_unit_assert.svh -----
// Assertion macros for the song step sequencer.
`ifndef MIDI_SONG_STEP_SEQUENCER_UNIT_ASSERT_SVH
`define MIDI_SONG_STEP_SEQUENCER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MSSS_ASSERT_SAME(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("sequencer assertion failed");
`define MSSS_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("sequencer assertion failed");
`else
`define MSSS_ASSERT_SAME(lbl, clk, rstn, cond, prop)
`define MSSS_ASSERT_NEXT(lbl, clk, rstn, cond, prop)
`endif

`endif

// ----- rtl/core/msss_pkg.sv -----
// Types, constants and tone table of the song step sequencer.
package msss_pkg;

    localparam int SONG_DEPTH_DEF = 1024;

    localparam int ELAPSED_W  = 16;
    localparam int ADDR_W     = 10;
    localparam int WORD_W     = 16;
    localparam int NOTE_W     = 7;
    localparam int FREQ_W     = 16;
    localparam int STATUS_W   = 8;
    localparam int SW_W       = 11;
    localparam int OCT_W      = 3;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_REWIND = 2'd2;
    localparam logic [1:0] MODE_PAUSE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SONG_WORDS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_SHIFT = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_NOTE_ON  = 8'h91;
    localparam logic [STATUS_W-1:0] STATUS_NOTE_OFF = 8'h81;

    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;
    localparam logic [NOTE_W-1:0] VEL_ON   = 7'd127;
    localparam logic [NOTE_W-1:0] VEL_OFF  = 7'd0;

    localparam logic [SW_W-1:0]  SONG_WORDS_RST = 11'd2;
    localparam logic [OCT_W-1:0] OCTAVE_RST     = 3'b111;

    localparam int SEMI_PER_STEP = 13;

    localparam int          DIV5_SHIFT = 21;
    localparam logic [18:0] DIV5_MUL   = 19'd419431;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ELAPSED_W-1:0] elapsed;
        logic [ADDR_W-1:0]    load_addr;
        logic [WORD_W-1:0]    load_word;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status_byte;
        logic [NOTE_W-1:0]   note_number;
        logic [NOTE_W-1:0]   velocity;
        logic                tone_valid;
        logic [FREQ_W-1:0]   tone_freq;
        logic                last;
    } out_t;

    localparam logic [FREQ_W-1:0] TONE_ROM [128] = '{
        16'd8, 16'd8, 16'd9, 16'd9, 16'd10, 16'd10, 16'd11, 16'd12,
        16'd12, 16'd13, 16'd14, 16'd15, 16'd16, 16'd17, 16'd18, 16'd19,
        16'd20, 16'd21, 16'd23, 16'd24, 16'd25, 16'd27, 16'd29, 16'd30,
        16'd32, 16'd34, 16'd36, 16'd38, 16'd41, 16'd43, 16'd46, 16'd48,
        16'd51, 16'd55, 16'd58, 16'd61, 16'd65, 16'd69, 16'd73, 16'd77,
        16'd82, 16'd87, 16'd92, 16'd97, 16'd103, 16'd110, 16'd116, 16'd123,
        16'd130, 16'd138, 16'd146, 16'd155, 16'd164, 16'd174, 16'd184, 16'd195,
        16'd207, 16'd220, 16'd233, 16'd246, 16'd261, 16'd277, 16'd293, 16'd311,
        16'd329, 16'd349, 16'd369, 16'd391, 16'd415, 16'd440, 16'd466, 16'd493,
        16'd523, 16'd554, 16'd587, 16'd622, 16'd659, 16'd698, 16'd739, 16'd783,
        16'd830, 16'd880, 16'd932, 16'd987, 16'd1046, 16'd1108, 16'd1174, 16'd1244,
        16'd1318, 16'd1396, 16'd1479, 16'd1567, 16'd1661, 16'd1760, 16'd1864, 16'd1975,
        16'd2093, 16'd2217, 16'd2349, 16'd2489, 16'd2637, 16'd2793, 16'd2959, 16'd3135,
        16'd3322, 16'd3520, 16'd3729, 16'd3951, 16'd4186, 16'd4434, 16'd4698, 16'd4978,
        16'd5274, 16'd5587, 16'd5919, 16'd6271, 16'd6644, 16'd7040, 16'd7458, 16'd7902,
        16'd8372, 16'd8869, 16'd9397, 16'd9956, 16'd10548, 16'd11175, 16'd11839, 16'd12543
    };

endpackage

// ----- rtl/core/midi_song_step_sequencer_unit.sv -----
// Song step sequencer top level: song memory, countdown, MIDI message output.
//
// Input channel s_valid/s_ready/s_payload carries commands: tick, load song
// word, rewind, toggle pause. Result channel m_valid/m_ready/m_data carries
// MIDI messages; the final message of a command has last set. Configuration
// writes arrive on cfg_valid/cfg_ready/cfg_index/cfg_data and are always taken.
// A tick that reaches zero or below reads a note/duration pair from two
// copies of the song memory (registered read), applies it once the output
// is free and emits one or two messages through the output register, the
// second from the second-message register. Such a tick holds off new
// commands from the memory read until the countdown update; a pause toggle
// likewise holds them off and gives one message; other commands give none.
// An output register and a second-message register part the channels:
// commands are taken while messages wait, and a stalled receiver holds the
// pending tick or pause until the output frees.
// Reset clears pointer, countdown, previous note, pause and the registers to
// their defaults; song memory content is undefined until loaded.
`include "midi_song_step_sequencer_unit_assert.svh"

module midi_song_step_sequencer_unit
    import msss_pkg::*;
#(
    parameter int SONG_DEPTH = SONG_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;
    localparam int LW = (PW + 2 > SW_W + 1) ? PW + 2 : SW_W + 1;
    localparam int AW = (PW > ADDR_W) ? PW : ADDR_W;

    logic [SW_W-1:0]         song_words_reg;
    logic signed [OCT_W-1:0] octave_reg;
    logic [PW-1:0]           play_ptr_reg;
    logic [CNT_W-1:0]        countdown_reg;
    logic [NOTE_W-1:0]       prev_note_reg;
    logic                    paused_reg;
    logic                    s1_valid_reg;
    logic                    s1_tick_reg;
    logic                    out_valid_reg;
    logic                    pend_valid_reg;
    out_t                    out_reg;
    out_t                    pend_reg;

    logic                    acc;
    logic                    tick_acc;
    logic                    load_we;
    logic                    proc;
    logic [AW:0]             load_addr_ext;
    logic [AW-1:0]           load_addr_w;
    logic [PW:0]             a1_ext;
    logic [PW-1:0]           rd_addr_b;
    logic [WORD_W-1:0]       word_note;
    logic [WORD_W-1:0]       word_dur;
    logic [CNT_W:0]          diff;
    logic [CNT_W-1:0]        cnt_sub;
    logic                    fire;
    logic [LW-1:0]           len;
    logic [LW-1:0]           next_ptr_ext;
    logic [PW-1:0]           ptr_adv;
    logic signed [17:0]      n_sum;
    logic [NOTE_W-1:0]       note;
    logic [17:0]             dur_x4;
    logic [36:0]             dur_prod;
    logic [WORD_W-1:0]       dur_q;
    logic [WORD_W-1:0]       dur_t;
    out_t                    msg1;
    out_t                    msg2;
    logic                    two_msgs;

    assign cfg_ready = 1'b1;
    assign s_ready   = !s1_valid_reg;
    assign acc       = s_valid && s_ready;
    assign tick_acc  = acc && (s_payload.mode == MODE_TICK) && !paused_reg;
    assign proc      = s1_valid_reg && !pend_valid_reg && (!out_valid_reg || m_ready);

    assign load_addr_ext = (AW + 1)'(s_payload.load_addr);
    assign load_addr_w   = load_addr_ext[AW-1:0];
    assign load_we       = acc && (s_payload.mode == MODE_LOAD)
                           && (load_addr_ext < (AW + 1)'(SONG_DEPTH));

    assign a1_ext    = (PW + 1)'(play_ptr_reg) + (PW + 1)'(1);
    assign rd_addr_b = (a1_ext >= (PW + 1)'(SONG_DEPTH)) ? '0 : a1_ext[PW-1:0];

    msss_ram #(.WIDTH(WORD_W), .DEPTH(SONG_DEPTH)) u_ram_note (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (load_addr_w[PW-1:0]),
        .wdata (s_payload.load_word),
        .re    (tick_acc),
        .raddr (play_ptr_reg),
        .rdata (word_note)
    );

    msss_ram #(.WIDTH(WORD_W), .DEPTH(SONG_DEPTH)) u_ram_dur (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (load_addr_w[PW-1:0]),
        .wdata (s_payload.load_word),
        .re    (tick_acc),
        .raddr (rd_addr_b),
        .rdata (word_dur)
    );

    always_comb begin
        diff = {countdown_reg[CNT_W-1], countdown_reg} - (CNT_W + 1)'(s_payload.elapsed);
        if (diff[CNT_W] && !diff[CNT_W-1]) begin
            cnt_sub = {1'b1, {(CNT_W - 1){1'b0}}};
        end else begin
            cnt_sub = diff[CNT_W-1:0];
        end
        fire = cnt_sub[CNT_W-1] || (cnt_sub == '0);
    end

    always_comb begin
        len = LW'(song_words_reg);
        if (len > LW'(SONG_DEPTH)) begin
            len = LW'(SONG_DEPTH);
        end
        if (len < LW'(2)) begin
            len = LW'(2);
        end
        next_ptr_ext = LW'(play_ptr_reg) + LW'(2);
        ptr_adv      = (next_ptr_ext >= len) ? '0 : next_ptr_ext[PW-1:0];
    end

    always_comb begin
        n_sum = $signed({2'b00, word_note}) + 18'(octave_reg) * 18'sd13;
        if (n_sum < 18'sd0) begin
            note = '0;
        end else if (n_sum > 18'sd127) begin
            note = NOTE_MAX;
        end else begin
            note = n_sum[NOTE_W-1:0];
        end
        dur_x4   = {word_dur, 2'b00};
        dur_prod = 37'(dur_x4) * 37'(DIV5_MUL);
        dur_q    = dur_prod[DIV5_SHIFT +: WORD_W];
        dur_t    = (dur_q == '0) ? WORD_W'(1) : dur_q;
    end

    always_comb begin
        msg1.status_byte = STATUS_NOTE_OFF;
        msg1.note_number = prev_note_reg;
        msg1.velocity    = (prev_note_reg != '0) ? VEL_ON : VEL_OFF;
        msg1.tone_valid  = 1'b1;
        msg1.tone_freq   = '0;
        msg1.last        = 1'b1;
        msg2.status_byte = STATUS_NOTE_ON;
        msg2.note_number = note;
        msg2.velocity    = VEL_ON;
        msg2.tone_valid  = 1'b1;
        msg2.tone_freq   = TONE_ROM[note];
        msg2.last        = 1'b1;
        two_msgs         = s1_tick_reg && (note != '0);
        if (two_msgs) begin
            msg1.tone_valid = 1'b0;
            msg1.last       = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            song_words_reg <= SONG_WORDS_RST;
            octave_reg     <= OCTAVE_RST;
            play_ptr_reg   <= '0;
            countdown_reg  <= '0;
            prev_note_reg  <= '0;
            paused_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s1_tick_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SONG_WORDS:   song_words_reg <= cfg_data[SW_W-1:0];
                    CFG_OCTAVE_SHIFT: octave_reg     <= cfg_data[OCT_W-1:0];
                    default: ;
                endcase
            end
            if (acc) begin
                case (s_payload.mode)
                    MODE_TICK: begin
                        if (!paused_reg) begin
                            countdown_reg <= cnt_sub;
                            s1_valid_reg  <= fire;
                            s1_tick_reg   <= 1'b1;
                        end
                    end
                    MODE_REWIND: play_ptr_reg <= '0;
                    MODE_PAUSE: begin
                        paused_reg   <= !paused_reg;
                        s1_valid_reg <= 1'b1;
                        s1_tick_reg  <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (proc) begin
                s1_valid_reg   <= 1'b0;
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= two_msgs;
                if (s1_tick_reg) begin
                    countdown_reg <= countdown_reg + CNT_W'(dur_t);
                    play_ptr_reg  <= ptr_adv;
                    prev_note_reg <= note;
                end
            end else if (pend_valid_reg && (!out_valid_reg || m_ready)) begin
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            out_reg  <= msg1;
            pend_reg <= msg2;
        end else if (pend_valid_reg && (!out_valid_reg || m_ready)) begin
            out_reg <= pend_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `MSSS_ASSERT_SAME(a_pend_behind_out, aclk, aresetn, pend_valid_reg, out_valid_reg)
    `MSSS_ASSERT_NEXT(a_second_follows, aclk, aresetn, pend_valid_reg && m_valid && m_ready, m_valid && m_data.last)
    `MSSS_ASSERT_NEXT(a_out_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `MSSS_ASSERT_SAME(a_ptr_even, aclk, aresetn, 1'b1, play_ptr_reg[0] == 1'b0)

endmodule

// ----- rtl/core/msss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module msss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
